/* rtl/imutp_pkg.sv */
// shared types and constants of the triple-frame imu burst parser
`default_nettype none

package imutp_pkg;

   localparam int unsigned FRAME_LEN   = 11;
   localparam int unsigned NUM_FRAMES  = 3;
   localparam int unsigned NUM_STAGED  = 10;
   localparam int unsigned OFFSET_W    = 4;
   localparam int unsigned FRAME_W     = 2;
   localparam int unsigned STAGE_IDX_W = 4;

   localparam logic [7:0] HDR_BYTE  = 8'h55;
   localparam logic [7:0] TYPE_BASE = 8'h51;

   // temperature: round(raw*5/17) + 3653, division by 17 as reciprocal multiply
   localparam int unsigned    TEMP_ABS_W   = 18;
   localparam int unsigned    TEMP_Q_W     = 14;
   localparam int unsigned    TEMP_SHIFT   = 22;
   localparam logic [17:0]    TEMP_RECIP   = 18'd246724;
   localparam logic [17:0]    TEMP_ROUND   = 18'd8;
   localparam logic [15:0]    TEMP_OFFSET  = 16'd3653;
   localparam int unsigned    TEMP_W       = 15;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_LEN_ERR = 2'd1,
      ST_HDR_ERR = 2'd2
   } imutp_status_type;

   typedef struct packed {
      logic                  len_ok;
      logic                  hdr_ok;
      logic [NUM_FRAMES-1:0] good;
   } imutp_burst_type;

endpackage

`default_nettype wire

/* rtl/imutp_byte_tracker.sv */
// per-byte burst tracking: position, checksum, header and type flags, value staging
`default_nettype none

module imutp_byte_tracker
   import imutp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  take,
   input  wire logic [7:0]            rx_byte,
   input  wire logic                  burst_end,
   output imutp_burst_type            burst,
   output logic [15:0]                staged [NUM_STAGED]
);

   logic [FRAME_W-1:0]     frame_ff, frame_in;
   logic [OFFSET_W-1:0]    offset_ff, offset_in;
   logic [7:0]             sum_ff, sum_in;
   logic [NUM_FRAMES-1:0]  hdr_ff, hdr_in;
   logic [NUM_FRAMES-1:0]  good_ff, good_in;
   logic [7:0]             low_ff, low_in;
   logic                   stage_we;
   logic [STAGE_IDX_W-1:0] stage_idx;
   logic [STAGE_IDX_W-1:0] stage_base;
   logic [15:0]            staged_ff [NUM_STAGED];

   always_comb begin
      frame_in   = frame_ff;
      offset_in  = offset_ff;
      sum_in     = sum_ff;
      hdr_in     = hdr_ff;
      good_in    = good_ff;
      low_in     = low_ff;
      stage_we   = 1'b0;
      case (frame_ff)
         2'd0:    stage_base = STAGE_IDX_W'(0);
         2'd1:    stage_base = STAGE_IDX_W'(4);
         default: stage_base = STAGE_IDX_W'(7);
      endcase
      stage_idx = stage_base + STAGE_IDX_W'(offset_ff[OFFSET_W-1:1]) - STAGE_IDX_W'(1);
      if (frame_ff == FRAME_W'(NUM_FRAMES)) begin
         // past the last frame: count once more so an overlong burst never reads as 33
         if (offset_ff == '0) offset_in = OFFSET_W'(1);
      end else begin
         if (offset_ff == OFFSET_W'(FRAME_LEN - 1)) begin
            offset_in = '0;
            frame_in  = frame_ff + FRAME_W'(1);
         end else begin
            offset_in = offset_ff + OFFSET_W'(1);
         end
         case (offset_ff)
            4'd0: begin
               sum_in = rx_byte;
               if (rx_byte == HDR_BYTE) hdr_in[frame_ff] = 1'b1;
            end
            4'd1: begin
               sum_in = sum_ff + rx_byte;
               if (rx_byte == TYPE_BASE + 8'(frame_ff)) good_in[frame_ff] = 1'b1;
            end
            4'd10: begin
               if (rx_byte != sum_ff) good_in[frame_ff] = 1'b0;
            end
            default: begin
               sum_in = sum_ff + rx_byte;
               if (!offset_ff[0]) begin
                  low_in = rx_byte;
               end else if (frame_ff == '0 || offset_ff < OFFSET_W'(8)) begin
                  stage_we = 1'b1;
               end
            end
         endcase
      end
   end

   assign burst.len_ok = (frame_in == FRAME_W'(NUM_FRAMES)) && (offset_in == '0);
   assign burst.hdr_ok = &hdr_in;
   assign burst.good   = good_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff  <= '0;
         offset_ff <= '0;
         sum_ff    <= '0;
         hdr_ff    <= '0;
         good_ff   <= '0;
      end else if (take) begin
         if (burst_end) begin
            frame_ff  <= '0;
            offset_ff <= '0;
            sum_ff    <= '0;
            hdr_ff    <= '0;
            good_ff   <= '0;
         end else begin
            frame_ff  <= frame_in;
            offset_ff <= offset_in;
            sum_ff    <= sum_in;
            hdr_ff    <= hdr_in;
            good_ff   <= good_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) low_ff <= low_in;
      if (take && stage_we) staged_ff[stage_idx] <= {rx_byte, low_ff};
   end

   assign staged = staged_ff;

endmodule

`default_nettype wire

/* rtl/imutp_temp_scale.sv */
// three-stage conversion of the raw temperature word to centidegrees
`default_nettype none

module imutp_temp_scale
   import imutp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic signed [15:0]       raw,
   output logic signed [TEMP_W-1:0]      centi
);

   logic signed [18:0]       n5;
   logic [TEMP_ABS_W-1:0]    abs_ff, abs_in;
   logic                     neg1_ff, neg2_ff;
   logic [35:0]              prod;
   logic [TEMP_Q_W-1:0]      q_ff;
   logic [15:0]              signed_q;
   logic [15:0]              sum;
   logic [TEMP_W-1:0]        centi_ff;

   always_comb begin
      n5     = 19'(raw) * 19'sd5;
      abs_in = (n5 < 0) ? TEMP_ABS_W'(-n5) : TEMP_ABS_W'(n5);
      abs_in = abs_in + TEMP_ROUND;
   end

   // floor(a/17) exact for a below 2^20 with this reciprocal
   assign prod     = 36'(abs_ff) * 36'(TEMP_RECIP);
   assign signed_q = neg2_ff ? (16'd0 - 16'(q_ff)) : 16'(q_ff);
   assign sum      = signed_q + TEMP_OFFSET;

   always_ff @(posedge clock) begin
      abs_ff   <= abs_in;
      neg1_ff  <= raw[15];
      q_ff     <= prod[TEMP_SHIFT +: TEMP_Q_W];
      neg2_ff  <= neg1_ff;
      centi_ff <= sum[TEMP_W-1:0];
   end

   assign centi = centi_ff;

endmodule

`default_nettype wire

/* rtl/imu_triple_frame_parser.sv */
// top level of the triple-frame imu burst parser
// Bytes of a sensor burst enter on the req_ channel, one beat per byte, with
// req_burst_end high on the last byte. A burst of exactly 33 bytes holds three
// 11-byte frames (header 0x55, type 0x51/0x52/0x53, data, additive checksum).
// Each byte beat takes one cycle and a new byte may be taken every cycle: the
// per-byte work is a single pass through the byte tracker into its registers.
// A byte with req_burst_end gives one rsp_ beat in the next cycle, carrying the
// status, the valid flag and all held values; frames whose type and checksum
// matched are committed only when length and headers are right.
// The temperature is rescaled by a three-stage pipeline fed from the staged
// raw word, which settles long before the checksum byte of the last frame.
// rsp_ outputs are registers; while a result waits under rsp_stall, bytes
// without the end flag are still taken, and only an end byte is stalled.
// Reset clears the burst state, the held values and the valid flag; no rsp_
// beat is shown until the first burst end.
`default_nettype none

module imu_triple_frame_parser
   import imutp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_rx_byte,
   input  wire logic                req_burst_end,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_status,
   output logic                     rsp_values_valid,
   output logic signed [15:0]       rsp_accel_x,
   output logic signed [15:0]       rsp_accel_y,
   output logic signed [15:0]       rsp_accel_z,
   output logic signed [TEMP_W-1:0] rsp_temperature_centi,
   output logic signed [15:0]       rsp_rate_x,
   output logic signed [15:0]       rsp_rate_y,
   output logic signed [15:0]       rsp_rate_z,
   output logic signed [15:0]       rsp_roll_angle,
   output logic signed [15:0]       rsp_pitch_angle,
   output logic signed [15:0]       rsp_yaw_angle
);

   logic                     take;
   logic                     end_take;
   imutp_burst_type          burst;
   logic [15:0]              staged [NUM_STAGED];
   logic signed [TEMP_W-1:0] temp_centi;
   imutp_status_type         status_in;
   logic [1:0]               status_ff;
   logic                     rsp_valid_ff;
   logic                     values_valid_ff;
   logic [15:0]              held_ff [9];
   logic [TEMP_W-1:0]        held_temp_ff;

   assign req_stall = rsp_valid_ff & rsp_stall & req_burst_end;
   assign take      = req_valid & ~req_stall;
   assign end_take  = take & req_burst_end;

   imutp_byte_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .rx_byte   (req_rx_byte),
      .burst_end (req_burst_end),
      .burst     (burst),
      .staged    (staged)
   );

   imutp_temp_scale u_temp (
      .clock (clock),
      .raw   (signed'(staged[3])),
      .centi (temp_centi)
   );

   always_comb begin
      if (!burst.len_ok)      status_in = ST_LEN_ERR;
      else if (!burst.hdr_ok) status_in = ST_HDR_ERR;
      else                    status_in = ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         values_valid_ff <= 1'b0;
         status_ff       <= ST_OK;
         held_temp_ff    <= '0;
         for (int i = 0; i < 9; i++) held_ff[i] <= '0;
      end else begin
         if (end_take) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (end_take) begin
            status_ff       <= status_in;
            values_valid_ff <= (status_in == ST_OK);
            if (status_in == ST_OK) begin
               if (burst.good[0]) begin
                  for (int i = 0; i < 3; i++) held_ff[i] <= staged[i];
                  held_temp_ff <= temp_centi;
               end
               if (burst.good[1]) begin
                  for (int i = 0; i < 3; i++) held_ff[3 + i] <= staged[4 + i];
               end
               if (burst.good[2]) begin
                  for (int i = 0; i < 3; i++) held_ff[6 + i] <= staged[7 + i];
               end
            end
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_values_valid      = values_valid_ff;
   assign rsp_accel_x           = held_ff[0];
   assign rsp_accel_y           = held_ff[1];
   assign rsp_accel_z           = held_ff[2];
   assign rsp_temperature_centi = held_temp_ff;
   assign rsp_rate_x            = held_ff[3];
   assign rsp_rate_y            = held_ff[4];
   assign rsp_rate_z            = held_ff[5];
   assign rsp_roll_angle        = held_ff[6];
   assign rsp_pitch_angle       = held_ff[7];
   assign rsp_yaw_angle         = held_ff[8];

   a_end_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_burst_end) |=> rsp_valid)
      else $error("end beat taken without a result beat following");

   a_ok_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_OK)) |-> rsp_values_valid)
      else $error("ok status without values valid");

   a_held_stable: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && !req_stall && req_burst_end) |=>
         ($stable(rsp_accel_x) && $stable(rsp_rate_x) && $stable(rsp_yaw_angle)
          && $stable(rsp_temperature_centi)))
      else $error("held values changed without a burst end");

endmodule

`default_nettype wire

/* tb/sv/imu_triple_frame_parser_tb.sv */
// self-checking testbench for the triple-frame imu burst parser
`default_nettype none

module imu_triple_frame_parser_tb;
   import imutp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned BURST_BYTES   = NUM_FRAMES * FRAME_LEN;
   localparam int unsigned POS_LIMIT     = BURST_BYTES + 1;
   localparam int unsigned NUM_HELD      = 9;
   localparam int unsigned RESET_CYCLES  = 8;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned RANDOM_BYTES  = 340;
   localparam int unsigned RANDOM_BURSTS = 12;
   localparam int unsigned PHASE_BURSTS  = 3;
   localparam int unsigned NUM_PHASES    = 4;
   localparam int unsigned TIMEOUT_NS    = 1_000_000;

   typedef struct {
      logic [7:0]  rx_byte;
      logic        burst_end;
      int unsigned gap_pct;
      int unsigned stall_pct;
      bit          drain;
   } byte_beat_type;

   typedef struct packed {
      imutp_status_type          status;
      logic                      values_valid;
      logic [NUM_HELD-1:0][15:0] held;
      logic [TEMP_W-1:0]         temperature;
   } imu_snapshot_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [7:0]               req_rx_byte = 8'd0;
   logic                     req_burst_end = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [1:0]               rsp_status;
   logic                     rsp_values_valid;
   logic signed [15:0]       rsp_accel_x, rsp_accel_y, rsp_accel_z;
   logic signed [TEMP_W-1:0] rsp_temperature_centi;
   logic signed [15:0]       rsp_rate_x, rsp_rate_y, rsp_rate_z;
   logic signed [15:0]       rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle;

   imu_triple_frame_parser dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_rx_byte           (req_rx_byte),
      .req_burst_end         (req_burst_end),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_values_valid      (rsp_values_valid),
      .rsp_accel_x           (rsp_accel_x),
      .rsp_accel_y           (rsp_accel_y),
      .rsp_accel_z           (rsp_accel_z),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_rate_x            (rsp_rate_x),
      .rsp_rate_y            (rsp_rate_y),
      .rsp_rate_z            (rsp_rate_z),
      .rsp_roll_angle        (rsp_roll_angle),
      .rsp_pitch_angle       (rsp_pitch_angle),
      .rsp_yaw_angle         (rsp_yaw_angle)
   );

   always #4 clock = ~clock;

   byte_beat_type    byte_backlog [$];
   imu_snapshot_type pending_snapshots [$];
   int unsigned      stall_pct = 0;
   int               ends_taken = 0;
   int               results_seen = 0;
   int               bytes_taken = 0;
   int               mismatch_count = 0;

   string held_name [NUM_HELD] = '{"accel_x", "accel_y", "accel_z", "rate_x", "rate_y",
                                   "rate_z", "roll_angle", "pitch_angle", "yaw_angle"};

   // parser state as the block should hold it
   logic [5:0]                parse_pos;
   logic [7:0]                frame_sum [NUM_FRAMES];
   logic [NUM_FRAMES-1:0]     hdr_seen;
   logic [NUM_FRAMES-1:0]     frame_good;
   logic [7:0]                low_hold;
   logic [15:0]               staged [NUM_STAGED];
   logic [NUM_HELD-1:0][15:0] held_vals;
   logic [TEMP_W-1:0]         held_temp;
   logic                      held_valid;

   function automatic logic [TEMP_W-1:0] centi_from_raw(input logic [15:0] raw);
      int n, mag, q, t;
      n = int'($signed(raw)) * 5;
      mag = (n < 0) ? -n : n;
      q = (mag + 8) / 17;
      t = ((n < 0) ? -q : q) + int'(TEMP_OFFSET);
      return t[TEMP_W-1:0];
   endfunction

   task automatic clear_burst_state();
      parse_pos = '0;
      for (int f = 0; f < NUM_FRAMES; f++) frame_sum[f] = '0;
      hdr_seen = '0;
      frame_good = '0;
      low_hold = '0;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic last);
      int               p, f, o, idx;
      imu_snapshot_type snap;
      p = parse_pos;
      if (p >= BURST_BYTES) begin
         if (p < POS_LIMIT) parse_pos = parse_pos + 1'b1;
      end else begin
         parse_pos = parse_pos + 1'b1;
         f = p / FRAME_LEN;
         o = p % FRAME_LEN;
         if (o < FRAME_LEN - 1) frame_sum[f] = frame_sum[f] + b;
         if (o == 0) begin
            if (b == HDR_BYTE) hdr_seen[f] = 1'b1;
         end else if (o == 1) begin
            if (b == 8'(TYPE_BASE + f)) frame_good[f] = 1'b1;
         end else if (o == FRAME_LEN - 1) begin
            if (b != frame_sum[f]) frame_good[f] = 1'b0;
         end else if (f == 0 || o < 8) begin
            // rate and angle frames carry a spare word that only feeds the sum
            idx = (f == 0) ? (o - 2) / 2 : 4 + (f - 1) * 3 + (o - 2) / 2;
            if (o % 2 == 0) low_hold = b;
            else staged[idx] = {b, low_hold};
         end
      end
      if (last) begin
         if (parse_pos != BURST_BYTES) begin
            snap.status = ST_LEN_ERR;
            held_valid = 1'b0;
         end else if (hdr_seen != '1) begin
            snap.status = ST_HDR_ERR;
            held_valid = 1'b0;
         end else begin
            snap.status = ST_OK;
            if (frame_good[0]) begin
               for (int i = 0; i < 3; i++) held_vals[i] = staged[i];
               held_temp = centi_from_raw(staged[3]);
            end
            if (frame_good[1]) for (int i = 0; i < 3; i++) held_vals[3 + i] = staged[4 + i];
            if (frame_good[2]) for (int i = 0; i < 3; i++) held_vals[6 + i] = staged[7 + i];
            held_valid = 1'b1;
         end
         clear_burst_state();
         snap.values_valid = held_valid;
         snap.held = held_vals;
         snap.temperature = held_temp;
         pending_snapshots.push_back(snap);
      end
   endtask

   // byte driver
   always @(posedge clock) begin : drive_bytes
      byte_beat_type beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_byte(req_rx_byte, req_burst_end);
            if (req_burst_end) ends_taken++;
            bytes_taken <= bytes_taken + 1;
         end
         if (!req_valid || !req_stall) begin
            if (byte_backlog.size() > 0 &&
                !(byte_backlog[0].drain && ends_taken > results_seen) &&
                $urandom_range(99) >= byte_backlog[0].gap_pct) begin
               beat = byte_backlog.pop_front();
               req_rx_byte <= beat.rx_byte;
               req_burst_end <= beat.burst_end;
               stall_pct <= beat.stall_pct;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic flag_field(input string field, input logic signed [31:0] want,
                             input logic signed [31:0] got);
      $display("%0t %s: expected %0d, got %0d", $time, field, want, got);
      mismatch_count++;
   endtask

   task automatic check_snapshot(input imu_snapshot_type want, input imu_snapshot_type got);
      if (got.status !== want.status) flag_field("status", want.status, got.status);
      if (got.values_valid !== want.values_valid)
         flag_field("values_valid", want.values_valid, got.values_valid);
      for (int i = 0; i < NUM_HELD; i++)
         if (got.held[i] !== want.held[i])
            flag_field(held_name[i], $signed(want.held[i]), $signed(got.held[i]));
      if (got.temperature !== want.temperature)
         flag_field("temperature_centi", $signed(want.temperature), $signed(got.temperature));
   endtask

   // result monitor
   always @(posedge clock) begin : watch_results
      imu_snapshot_type seen;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.status = imutp_status_type'(rsp_status);
            seen.values_valid = rsp_values_valid;
            seen.held = {rsp_yaw_angle, rsp_pitch_angle, rsp_roll_angle, rsp_rate_z, rsp_rate_y,
                         rsp_rate_x, rsp_accel_z, rsp_accel_y, rsp_accel_x};
            seen.temperature = rsp_temperature_centi;
            if (pending_snapshots.size() == 0) begin
               $display("%0t unexpected result beat: expected none, got status %0d", $time,
                        rsp_status);
               mismatch_count++;
            end else begin
               check_snapshot(pending_snapshots.pop_front(), seen);
            end
            results_seen <= results_seen + 1;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // stimulus generation
   int unsigned gap_by_phase [NUM_PHASES]   = '{0, 62, 0, 8};
   int unsigned stall_by_phase [NUM_PHASES] = '{0, 0, 62, 8};
   int unsigned gen_gap = 0;
   int unsigned gen_stall = 0;
   bit          gen_drain = 1'b0;
   int          total_bytes = 0;

   task automatic push_byte(input logic [7:0] b, input logic last);
      byte_beat_type beat;
      beat.rx_byte = b;
      beat.burst_end = last;
      beat.gap_pct = gen_gap;
      beat.stall_pct = gen_stall;
      beat.drain = gen_drain;
      gen_drain = 1'b0;
      byte_backlog.push_back(beat);
      total_bytes++;
   endtask

   task automatic seal_frame(inout logic [7:0] bb [BURST_BYTES], input int f);
      logic [7:0] sum;
      sum = '0;
      for (int o = 0; o < FRAME_LEN - 1; o++) sum = sum + bb[f * FRAME_LEN + o];
      bb[f * FRAME_LEN + FRAME_LEN - 1] = sum;
   endtask

   task automatic form_burst(output logic [7:0] bb [BURST_BYTES], input logic [15:0] word,
                             input bit random_data);
      for (int f = 0; f < NUM_FRAMES; f++) begin
         bb[f * FRAME_LEN] = HDR_BYTE;
         bb[f * FRAME_LEN + 1] = 8'(TYPE_BASE + f);
         for (int o = 2; o < FRAME_LEN - 1; o++)
            bb[f * FRAME_LEN + o] = random_data ? 8'($urandom) :
                                    ((o % 2 == 0) ? word[7:0] : word[15:8]);
         seal_frame(bb, f);
      end
   endtask

   // lengths past a full burst are padded with noise
   task automatic send_burst(input logic [7:0] bb [BURST_BYTES], input int len);
      for (int i = 0; i < len; i++)
         push_byte((i < BURST_BYTES) ? bb[i] : 8'($urandom), i == len - 1);
   endtask

   initial begin : stimulus
      logic [7:0] bb [BURST_BYTES];
      int         kind, len, f, phase, rnd_bursts, rnd_bytes;
      clear_burst_state();
      for (int i = 0; i < NUM_STAGED; i++) staged[i] = '0;
      held_vals = '0;
      held_temp = '0;
      held_valid = 1'b0;

      // directed bursts
      form_burst(bb, 16'h0000, 1'b0);
      send_burst(bb, BURST_BYTES);
      form_burst(bb, 16'h7FFF, 1'b0);
      send_burst(bb, BURST_BYTES);
      form_burst(bb, 16'h8000, 1'b0);
      send_burst(bb, BURST_BYTES);
      form_burst(bb, 16'hFFFF, 1'b0);
      send_burst(bb, BURST_BYTES);
      // checksum wrong on the accel frame only
      form_burst(bb, 16'h1234, 1'b0);
      bb[FRAME_LEN - 1] ^= 8'h01;
      send_burst(bb, BURST_BYTES);
      // angle frame carries the wrong type with a matching sum
      form_burst(bb, 16'h4321, 1'b0);
      bb[2 * FRAME_LEN + 1] = TYPE_BASE;
      seal_frame(bb, 2);
      send_burst(bb, BURST_BYTES);
      // every checksum wrong: valid set, nothing committed
      form_burst(bb, 16'h5A5A, 1'b0);
      for (int k = 0; k < NUM_FRAMES; k++) bb[k * FRAME_LEN + FRAME_LEN - 1] ^= 8'h80;
      send_burst(bb, BURST_BYTES);
      // rate frame header broken
      form_burst(bb, 16'h0101, 1'b1);
      bb[FRAME_LEN] = 8'hAA;
      send_burst(bb, BURST_BYTES);
      form_burst(bb, 16'h0000, 1'b1);
      send_burst(bb, BURST_BYTES);
      send_burst(bb, 1);
      send_burst(bb, BURST_BYTES - 1);
      send_burst(bb, BURST_BYTES + 7);
      form_burst(bb, 16'h0000, 1'b1);
      send_burst(bb, BURST_BYTES);

      // random bursts, mostly well formed, idling pattern changes every few bursts
      rnd_bursts = 0;
      rnd_bytes = 0;
      while (rnd_bytes < RANDOM_BYTES || rnd_bursts < RANDOM_BURSTS) begin
         if (rnd_bursts % PHASE_BURSTS == 0) begin
            phase = (rnd_bursts / PHASE_BURSTS) % NUM_PHASES;
            gen_gap = gap_by_phase[phase];
            gen_stall = stall_by_phase[phase];
            gen_drain = 1'b1;
         end
         kind = $urandom_range(99);
         form_burst(bb, 16'h0000, 1'b1);
         len = BURST_BYTES;
         if (kind < 70) begin
            for (int k = 0; k < NUM_FRAMES; k++) begin
               if ($urandom_range(99) < 10) begin
                  bb[k * FRAME_LEN + 1] = 8'($urandom);
                  seal_frame(bb, k);
               end
               if ($urandom_range(99) < 12)
                  bb[k * FRAME_LEN + FRAME_LEN - 1] ^= 8'($urandom_range(1, 255));
            end
         end else if (kind < 80) begin
            f = $urandom_range(NUM_FRAMES - 1);
            bb[f * FRAME_LEN] ^= 8'($urandom_range(1, 255));
         end else if (kind < 92) begin
            len = $urandom_range(1, BURST_BYTES + 12);
         end else begin
            for (int i = 0; i < BURST_BYTES; i++) bb[i] = 8'($urandom);
            len = $urandom_range(1, BURST_BYTES + 7);
         end
         send_burst(bb, len);
         rnd_bursts++;
         rnd_bytes += len;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      while (bytes_taken < total_bytes) @(posedge clock);
      while (pending_snapshots.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_snapshots.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
rtl/imutp_pkg.sv
rtl/imutp_byte_tracker.sv
rtl/imutp_temp_scale.sv
rtl/imu_triple_frame_parser.sv
tb/sv/imu_triple_frame_parser_tb.sv
